/* sv/zsbf_pkg.sv */
// shared types and constants of the zlib stored block framer
package zsbf_pkg;

  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // one classified raw byte with everything the back end needs to frame it
  typedef struct packed {
    logic [7:0]  data;
    logic        zhdr;      // zlib header goes first
    logic        bhdr;      // block header goes before the byte
    logic        bfinal;    // announced block is the last one
    logic [15:0] blen;      // announced block length
    logic        trailer;   // checksum follows the byte
    logic [15:0] adler_hi;
    logic [15:0] adler_lo;
  } entry_t;

  // output byte sequencer steps
  typedef enum logic [3:0] {
    ST_START,
    ST_CMF,
    ST_FLG,
    ST_BFINAL,
    ST_LEN0,
    ST_LEN1,
    ST_NLEN0,
    ST_NLEN1,
    ST_DATA,
    ST_ADL0,
    ST_ADL1,
    ST_ADL2,
    ST_ADL3
  } step_e;

endpackage

/* sv/zlib_stored_block_framer.sv */
// zlib stored block framer: raw bytes in, zlib stream with adler-32 trailer out
// a byte accepted passes the queue and the output register before its first output byte
// one output byte per cycle unless the queue is empty or the output stalls; a raw byte
//   gives one, plus two zlib header, five block header and four checksum trailer bytes
// the front end takes one byte per cycle until the QUEUE_DEPTH entry queue fills
// reset: async active low, clears stream state, queue and output; length resets to 1
module zlib_stored_block_framer #(
  parameter int unsigned MAX_BLOCK_BYTES = 65535,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        stream_end_o
);

  zsbf_pkg::entry_t push_entry, head_entry;
  logic             push, full, head_valid, pop;

  // a request is taken whenever the queue has room
  assign push       = in_valid_i && !full;
  assign in_stall_o = full;

  zsbf_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .data_byte_i(data_byte_i),
    .entry_o    (push_entry)
  );

  zsbf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head_entry)
  );

  zsbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .stream_end_o(stream_end_o)
  );

endmodule

/* sv/zsbf_front.sv */
// front end: takes raw bytes, tracks stream and block position and adler-32
module zsbf_front #(
  parameter int unsigned MAX_BLOCK_BYTES = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             push_i,
  input  logic [7:0]       data_byte_i,
  output zsbf_pkg::entry_t entry_o
);

  localparam logic [31:0] MaxBlock = 32'(MAX_BLOCK_BYTES);

  logic [31:0] total_q;
  logic [31:0] bytes_q, bytes_d;
  logic [15:0] left_q, left_d;
  logic [15:0] slow_q, slow_d;
  logic [15:0] shigh_q, shigh_d;

  logic [31:0] eff_total, remaining, blen32, bytes_next;
  logic [15:0] base, sl, sh;
  logic [16:0] sl_sum, sh_sum;
  logic        bhdr, trailer;

  // stream length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 32'd1;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // block length and end of stream decisions
  always_comb begin
    eff_total  = (total_q == 32'd0) ? 32'd1 : total_q;
    bhdr       = (left_q == 16'd0);
    remaining  = (eff_total > bytes_q) ? (eff_total - bytes_q) : 32'd1;
    blen32     = (remaining < MaxBlock) ? remaining : MaxBlock;
    base       = bhdr ? blen32[15:0] : left_q;
    bytes_next = bytes_q + 32'd1;
    trailer    = (bytes_next >= eff_total);
  end

  // adler-32 update, both sums reduced by one conditional subtract
  always_comb begin
    sl_sum = {1'b0, slow_q} + {9'd0, data_byte_i};
    sl     = (sl_sum >= zsbf_pkg::ADLER_MOD) ? 16'(sl_sum - zsbf_pkg::ADLER_MOD)
                                             : sl_sum[15:0];
    sh_sum = {1'b0, shigh_q} + {1'b0, sl};
    sh     = (sh_sum >= zsbf_pkg::ADLER_MOD) ? 16'(sh_sum - zsbf_pkg::ADLER_MOD)
                                             : sh_sum[15:0];
  end

  // entry handed to the queue
  always_comb begin
    entry_o.data     = data_byte_i;
    entry_o.zhdr     = bhdr && (bytes_q == 32'd0);
    entry_o.bhdr     = bhdr;
    entry_o.bfinal   = (blen32 >= remaining);
    entry_o.blen     = blen32[15:0];
    entry_o.trailer  = trailer;
    entry_o.adler_hi = sh;
    entry_o.adler_lo = sl;
  end

  // next stream state, back to the start after the last byte
  always_comb begin
    if (trailer) begin
      bytes_d = 32'd0;
      left_d  = 16'd0;
      slow_d  = 16'd1;
      shigh_d = 16'd0;
    end else begin
      bytes_d = bytes_next;
      left_d  = base - 16'd1;
      slow_d  = sl;
      shigh_d = sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= 32'd0;
      left_q  <= 16'd0;
      slow_q  <= 16'd1;
      shigh_q <= 16'd0;
    end else if (push_i) begin
      bytes_q <= bytes_d;
      left_q  <= left_d;
      slow_q  <= slow_d;
      shigh_q <= shigh_d;
    end
  end

endmodule

/* sv/zsbf_queue.sv */
// short fifo of classified entries between front and back end
module zsbf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  zsbf_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output zsbf_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  zsbf_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* sv/zsbf_back.sv */
// back end: walks each entry through its output bytes into an output register
module zsbf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  zsbf_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             stream_end_o
);

  zsbf_pkg::step_e step_q, step_d, cur, nxt;
  logic       adv, done;
  logic [7:0] byte_c;
  logic       end_c;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       oend_q;

  assign adv = valid_i && (!ovalid_q || !out_stall_i);

  // current step, a fresh entry starts at its first output byte
  always_comb begin
    if (step_q == zsbf_pkg::ST_START) begin
      if (entry_i.zhdr) begin
        cur = zsbf_pkg::ST_CMF;
      end else if (entry_i.bhdr) begin
        cur = zsbf_pkg::ST_BFINAL;
      end else begin
        cur = zsbf_pkg::ST_DATA;
      end
    end else begin
      cur = step_q;
    end
  end

  // next step
  always_comb begin
    done = 1'b0;
    case (cur)
      zsbf_pkg::ST_CMF:    nxt = zsbf_pkg::ST_FLG;
      zsbf_pkg::ST_FLG:    nxt = zsbf_pkg::ST_BFINAL;
      zsbf_pkg::ST_BFINAL: nxt = zsbf_pkg::ST_LEN0;
      zsbf_pkg::ST_LEN0:   nxt = zsbf_pkg::ST_LEN1;
      zsbf_pkg::ST_LEN1:   nxt = zsbf_pkg::ST_NLEN0;
      zsbf_pkg::ST_NLEN0:  nxt = zsbf_pkg::ST_NLEN1;
      zsbf_pkg::ST_NLEN1:  nxt = zsbf_pkg::ST_DATA;
      zsbf_pkg::ST_DATA: begin
        nxt  = entry_i.trailer ? zsbf_pkg::ST_ADL0 : zsbf_pkg::ST_START;
        done = !entry_i.trailer;
      end
      zsbf_pkg::ST_ADL0:   nxt = zsbf_pkg::ST_ADL1;
      zsbf_pkg::ST_ADL1:   nxt = zsbf_pkg::ST_ADL2;
      zsbf_pkg::ST_ADL2:   nxt = zsbf_pkg::ST_ADL3;
      zsbf_pkg::ST_ADL3: begin
        nxt  = zsbf_pkg::ST_START;
        done = 1'b1;
      end
      default: begin
        nxt  = zsbf_pkg::ST_START;
        done = 1'b1;
      end
    endcase
    step_d = adv ? nxt : step_q;
  end

  // byte produced at each step
  always_comb begin
    end_c = (cur == zsbf_pkg::ST_ADL3);
    case (cur)
      zsbf_pkg::ST_CMF:    byte_c = zsbf_pkg::ZLIB_CMF;
      zsbf_pkg::ST_FLG:    byte_c = zsbf_pkg::ZLIB_FLG;
      zsbf_pkg::ST_BFINAL: byte_c = {7'd0, entry_i.bfinal};
      zsbf_pkg::ST_LEN0:   byte_c = entry_i.blen[7:0];
      zsbf_pkg::ST_LEN1:   byte_c = entry_i.blen[15:8];
      zsbf_pkg::ST_NLEN0:  byte_c = ~entry_i.blen[7:0];
      zsbf_pkg::ST_NLEN1:  byte_c = ~entry_i.blen[15:8];
      zsbf_pkg::ST_DATA:   byte_c = entry_i.data;
      zsbf_pkg::ST_ADL0:   byte_c = entry_i.adler_hi[15:8];
      zsbf_pkg::ST_ADL1:   byte_c = entry_i.adler_hi[7:0];
      zsbf_pkg::ST_ADL2:   byte_c = entry_i.adler_lo[15:8];
      zsbf_pkg::ST_ADL3:   byte_c = entry_i.adler_lo[7:0];
      default:             byte_c = entry_i.data;
    endcase
  end

  assign pop_o = adv && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= zsbf_pkg::ST_START;
    end else begin
      step_q <= step_d;
    end
  end

  // output register, holds while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (!ovalid_q || !out_stall_i) begin
      ovalid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      obyte_q <= byte_c;
      oend_q  <= end_c;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign stream_end_o = oend_q;

endmodule

/* sv/zsbf_checker.sv */
// port level checks of the zlib stored block framer and their bind
module zsbf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_byte_i,
  input logic       stream_end_i
);

  logic expect_cmf_q, expect_flg_q, out_acc;

  assign out_acc = out_valid_i && !out_stall_i;

  // track where a new stream must begin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_cmf_q <= 1'b1;
      expect_flg_q <= 1'b0;
    end else if (out_acc) begin
      expect_cmf_q <= stream_end_i;
      expect_flg_q <= expect_cmf_q;
    end
  end

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i) && $stable(stream_end_i))
    else $error("output request changed while stalled");

  // a stream opens with the zlib header
  a_cmf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expect_cmf_q |-> out_byte_i == 8'h78 && !stream_end_i)
    else $error("stream does not open with cmf byte");

  a_flg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expect_flg_q |-> out_byte_i == 8'h01 && !stream_end_i)
    else $error("cmf byte not followed by flg byte");

  // nothing is offered once reset has been sampled active
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_i  (out_byte_o),
  .stream_end_i(stream_end_o)
);

/* test/zsbf_stream_checker.sv */
// stream checker for the zlib stored block framer: predicts the zlib bytes and compares them
module zsbf_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        stream_end_i,
  output int          fail_count_o,
  output int          bytes_due_o
);

  localparam logic [7:0]  CMF_BYTE   = 8'h78;
  localparam logic [7:0]  FLG_BYTE   = 8'h01;
  localparam logic [16:0] ADLER_BASE = 17'd65521;
  localparam logic [31:0] BLOCK_CAP  = 32'd65535;

  typedef struct packed {
    logic [7:0] value;
    logic       stream_end;
  } zbyte_t;

  // zlib bytes predicted but not yet seen on the output
  zbyte_t      zbytes_due[$];

  // predictor copy of the length register and the stream state
  logic [31:0] total_bytes;
  logic [31:0] bytes_taken;
  logic [15:0] block_left;
  logic [16:0] sum_low;
  logic [16:0] sum_high;
  int          failures = 0;

  task automatic due_byte(input logic [7:0] value, input logic stream_end);
    zbyte_t zb;
    zb.value      = value;
    zb.stream_end = stream_end;
    zbytes_due.insert(zbytes_due.size(), zb);
  endtask

  task automatic clear_stream();
    bytes_taken = 32'd0;
    block_left  = 16'd0;
    sum_low     = 17'd1;
    sum_high    = 17'd0;
  endtask

  // frame one raw byte: headers as due, the byte, then the trailer at stream end
  task automatic frame_byte(input logic [7:0] raw);
    logic [31:0] total;
    logic [31:0] remaining;
    logic [31:0] span;
    logic [15:0] blen;
    logic [15:0] nlen;
    logic        final_blk;
    total = (total_bytes == 32'd0) ? 32'd1 : total_bytes;

    // zlib header at the start of a stream
    if (bytes_taken == 32'd0 && block_left == 16'd0) begin
      due_byte(CMF_BYTE, 1'b0);
      due_byte(FLG_BYTE, 1'b0);
    end

    // stored block header; a total already passed announces a final block of one
    if (block_left == 16'd0) begin
      remaining = (total > bytes_taken) ? (total - bytes_taken) : 32'd1;
      span      = (remaining < BLOCK_CAP) ? remaining : BLOCK_CAP;
      final_blk = (span >= remaining);
      blen      = span[15:0];
      nlen      = ~blen;
      due_byte({7'd0, final_blk}, 1'b0);
      due_byte(blen[7:0], 1'b0);
      due_byte(blen[15:8], 1'b0);
      due_byte(nlen[7:0], 1'b0);
      due_byte(nlen[15:8], 1'b0);
      block_left = blen;
    end

    due_byte(raw, 1'b0);
    if (block_left != 16'd0) block_left = block_left - 16'd1;
    bytes_taken = bytes_taken + 32'd1;

    // adler-32 running sums
    sum_low = sum_low + {9'd0, raw};
    if (sum_low >= ADLER_BASE) sum_low = sum_low - ADLER_BASE;
    sum_high = sum_high + sum_low;
    if (sum_high >= ADLER_BASE) sum_high = sum_high - ADLER_BASE;

    // checksum trailer, big-endian, and re-arm for the next stream
    if (bytes_taken >= total) begin
      due_byte(sum_high[15:8], 1'b0);
      due_byte(sum_high[7:0], 1'b0);
      due_byte(sum_low[15:8], 1'b0);
      due_byte(sum_low[7:0], 1'b1);
      clear_stream();
    end
  endtask

  // compare accepted output bytes, then predict from accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    zbyte_t want;
    if (!rst_ni) begin
      zbytes_due.delete();
      total_bytes = 32'd1;
      clear_stream();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (zbytes_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected output: expected none, actual byte %02h end %0b",
                   $time, out_byte_i, stream_end_i);
        end else begin
          want = zbytes_due.pop_front();
          if (out_byte_i !== want.value) begin
            failures++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.value, out_byte_i);
          end
          if (stream_end_i !== want.stream_end) begin
            failures++;
            $display("%0t: stream_end mismatch: expected %0b, actual %0b",
                     $time, want.stream_end, stream_end_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) frame_byte(data_byte_i);
      if (cfg_we_i) total_bytes = cfg_wdata_i;
    end
    fail_count_o <= failures;
    bytes_due_o  <= zbytes_due.size();
  end

endmodule

/* test/tb_top.sv */
// testbench top for the zlib stored block framer: stimulus, idling and verdict
module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = 32'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        stream_end_o;

  int          fail_count;
  int          bytes_due;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  zlib_stored_block_framer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .stream_end_o (stream_end_o)
  );

  zsbf_stream_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .stream_end_i (stream_end_o),
    .fail_count_o (fail_count),
    .bytes_due_o  (bytes_due)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // offer one raw byte, idling at random first, and hold it until taken
  task automatic send_byte(input logic [7:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(255)));
  endtask

  // write the stream length once every due byte has come out
  task automatic load_total(input logic [31:0] total);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random streams: mostly whole short streams, some with the length changed partway
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned eff;
    int unsigned cut;
    int unsigned extra;
    logic [31:0] len;
    logic        huge;
    sent = 0;
    while (sent < n_items) begin
      huge = ($urandom_range(9) == 0);
      if (huge) len = $urandom | 32'h8000_0000;
      else begin
        case ($urandom_range(9))
          0:       len = 32'd0;
          1:       len = $urandom_range(13, 300);
          default: len = $urandom_range(1, 12);
        endcase
      end
      load_total(len);
      eff = (len == 32'd0) ? 1 : len;
      if (huge || $urandom_range(99) < 15) begin
        cut   = huge ? $urandom_range(1, 8) : $urandom_range(eff);
        extra = $urandom_range(1, 6);
        send_random(cut);
        load_total($urandom_range(0, (huge ? cut : eff) + 4));
        send_random(extra);
        sent += cut + extra;
      end else begin
        send_random(eff);
        sent += eff;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 16;
    recv_stall_pct = 46;

    // reset length of one: each byte is a whole stream
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero length acts as one
    load_total(32'd0);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // short well-formed stream
    load_total(32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    // length raised mid-block, then lowered below the bytes taken at a block start
    load_total(32'd3);
    send_byte(8'h11);
    send_byte(8'h22);
    load_total(32'd10);
    send_byte(8'h33);
    load_total(32'd2);
    send_byte(8'h44);
    // largest length, cut short inside the block
    load_total(32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h01);
    load_total(32'd2);
    send_byte(8'hFE);

    run_random(140);

    send_idle_pct  = 46;
    recv_stall_pct = 16;
    run_random(140);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(120);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
